[hdl/rip_packet_parser_assert.svh]
// assertion macros for the rip packet parser checker
// expects clk and rst_n in the scope where a macro is used
`ifndef RIP_PACKET_PARSER_ASSERT_SVH
`define RIP_PACKET_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rpp_pkg.sv]
// shared types and constants for the rip packet parser
// no dependencies
`default_nettype none

package rpp_pkg;

    localparam int HEADER_BYTES    = 4;
    localparam int ENTRY_BYTES     = 20;
    localparam int PASSWORD_BYTES  = 16;
    localparam int AUTH_PASS_START = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_AUTH_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASSWORD_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASSWORD_LOW  = 2'd2;

    localparam logic [9:0]  COUNT_CEILING = 10'd1023;
    localparam logic [15:0] AUTH_FAMILY   = 16'hFFFF;
    localparam logic [15:0] AUTH_TYPE     = 16'd2;

    localparam logic KIND_ROUTE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_TOO_SHORT,
        STATUS_PARTIAL,
        STATUS_AUTH_FAILED
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [15:0] address_family;
        logic [15:0] route_tag;
        logic [31:0] ip_address;
        logic [31:0] subnet_mask;
        logic [31:0] next_hop;
        logic [31:0] metric;
        logic        mask_valid;
        status_t     status;
        logic        end_of_run;
    } result_t;

    // results handed from the parser to the output buffer
    typedef struct packed {
        logic    push_a;
        logic    push_b;
        result_t res_a;
        result_t res_b;
    } push_t;

    // free space in the output buffer
    typedef struct packed {
        logic one;
        logic two;
    } room_t;

endpackage

`default_nettype wire

[hdl/rpp_if.sv]
// valid/ready channel interfaces for the rip packet parser
// depends on rpp_pkg for the status type
`default_nettype none

interface rpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpp_result_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [7:0]           command;
    logic [7:0]           version;
    logic [15:0]          address_family;
    logic [15:0]          route_tag;
    logic [31:0]          ip_address;
    logic [31:0]          subnet_mask;
    logic [31:0]          next_hop;
    logic [31:0]          metric;
    logic                 mask_valid;
    rpp_pkg::status_t     status;
    logic                 end_of_run;

    modport source (output valid, output kind, output command, output version,
                    output address_family, output route_tag, output ip_address,
                    output subnet_mask, output next_hop, output metric,
                    output mask_valid, output status, output end_of_run, input ready);
    modport sink   (input valid, input kind, input command, input version,
                    input address_family, input route_tag, input ip_address,
                    input subnet_mask, input next_hop, input metric,
                    input mask_valid, input status, input end_of_run, output ready);
endinterface

`default_nettype wire

[hdl/rpp_parser.sv]
// input word register, packet state and per-byte parse logic
// depends on rpp_pkg and rpp_byte_if
`default_nettype none

module rpp_parser
    import rpp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    rpp_byte_if.sink                    packet,
    input  wire room_t                  room,
    output push_t                       push
);

    // configuration
    logic         auth_enable_reg;
    logic [127:0] password_reg;

    // input word register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // packet state
    logic [9:0]   byte_count_reg, byte_count_next;
    logic [7:0]   command_reg, command_next;
    logic [7:0]   version_reg, version_next;
    logic [151:0] entry_sr_reg;
    logic [4:0]   entry_offset_reg, entry_offset_next;
    logic         pw_equal_reg, pw_equal_next;
    logic         pw_ended_reg, pw_ended_next;
    logic         auth_failed_reg, auth_failed_next;

    logic [7:0]   b;
    logic         in_header;
    logic [4:0]   off_eff;
    logic [4:0]   pass_off;
    logic [3:0]   pass_idx;
    logic [7:0]   cfg_byte;
    logic         compare_en;
    logic         entry_done;
    logic         auth_check;
    logic         auth_bad;
    logic         route_emit;
    logic         need_one, need_two, fire;
    logic [159:0] entry;
    logic [31:0]  mask_inv;
    logic [31:0]  mask_inv_inc;
    status_t      status_val;
    result_t      route_res, status_res;

    assign b = s1_byte_reg;

    always_comb
    begin
        byte_count_next = (byte_count_reg < COUNT_CEILING) ? byte_count_reg + 10'd1
                                                            : byte_count_reg;
        in_header  = byte_count_reg < 10'(HEADER_BYTES);
        off_eff    = (entry_offset_reg >= 5'(ENTRY_BYTES)) ? 5'd0 : entry_offset_reg;
        pass_off   = off_eff - 5'(AUTH_PASS_START);
        pass_idx   = pass_off[3:0];
        // byte 0 of the password sits in the top bits
        cfg_byte   = password_reg[{~pass_idx, 3'b000} +: 8];
        compare_en = !in_header && (byte_count_reg < 10'(HEADER_BYTES + ENTRY_BYTES))
                     && (off_eff >= 5'(AUTH_PASS_START))
                     && (off_eff < 5'(AUTH_PASS_START + PASSWORD_BYTES))
                     && !pw_ended_reg;
        pw_equal_next = pw_equal_reg && !(compare_en && (b != cfg_byte));
        pw_ended_next = pw_ended_reg || (compare_en && (b == cfg_byte) && (b == 8'd0));

        entry_done = !in_header && (off_eff == 5'(ENTRY_BYTES - 1));
        entry      = {entry_sr_reg, b};
        auth_check = entry_done && auth_enable_reg
                     && (byte_count_reg == 10'(HEADER_BYTES + ENTRY_BYTES - 1));
        auth_bad   = (entry[159:144] != AUTH_FAMILY) || (entry[143:128] != AUTH_TYPE)
                     || !pw_equal_next;
        auth_failed_next = auth_failed_reg || (auth_check && auth_bad);
        route_emit = entry_done && !auth_check && !auth_failed_reg;

        if (in_header)
            entry_offset_next = entry_offset_reg;
        else if (entry_done)
            entry_offset_next = 5'd0;
        else
            entry_offset_next = off_eff + 5'd1;

        command_next = (byte_count_reg == 10'd0) ? b : command_reg;
        version_next = (byte_count_reg == 10'd1) ? b : version_reg;

        priority if (byte_count_next < 10'(HEADER_BYTES))
            status_val = STATUS_TOO_SHORT;
        else if (entry_offset_next != 5'd0)
            status_val = STATUS_PARTIAL;
        else if (auth_enable_reg && (auth_failed_next
                 || byte_count_next < 10'(HEADER_BYTES + ENTRY_BYTES)))
            status_val = STATUS_AUTH_FAILED;
        else
            status_val = STATUS_OK;

        mask_inv     = ~entry[95:64];
        mask_inv_inc = mask_inv + 32'd1;

        route_res                = '0;
        route_res.kind           = KIND_ROUTE;
        route_res.command        = command_next;
        route_res.version        = version_next;
        route_res.address_family = entry[159:144];
        route_res.route_tag      = entry[143:128];
        route_res.ip_address     = entry[127:96];
        route_res.subnet_mask    = entry[95:64];
        route_res.next_hop       = entry[63:32];
        route_res.metric         = entry[31:0];
        route_res.mask_valid     = (mask_inv & mask_inv_inc) == 32'd0;
        route_res.status         = STATUS_OK;
        route_res.end_of_run     = !s1_last_reg;

        status_res            = '0;
        status_res.kind       = KIND_STATUS;
        status_res.command    = command_next;
        status_res.version    = version_next;
        status_res.status     = status_val;
        status_res.end_of_run = 1'b1;

        need_two = route_emit && s1_last_reg;
        need_one = route_emit || s1_last_reg;
        if (need_two)
            fire = s1_valid_reg && room.two;
        else if (need_one)
            fire = s1_valid_reg && room.one;
        else
            fire = s1_valid_reg;

        push.push_a = fire && need_one;
        push.push_b = fire && need_two;
        push.res_a  = route_emit ? route_res : status_res;
        push.res_b  = status_res;
    end

    assign packet.ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auth_enable_reg <= 1'b0;
            password_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_AUTH_ENABLE:   auth_enable_reg       <= cfg_data[0];
                CFG_PASSWORD_HIGH: password_reg[127:64]  <= cfg_data;
                CFG_PASSWORD_LOW:  password_reg[63:0]    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (packet.ready)
            s1_valid_reg <= packet.valid;
    end

    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            s1_byte_reg <= packet.data_byte;
            s1_last_reg <= packet.last_byte;
        end
        if (fire && !in_header)
            entry_sr_reg <= {entry_sr_reg[143:0], b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            command_reg      <= '0;
            version_reg      <= '0;
            entry_offset_reg <= '0;
            pw_equal_reg     <= 1'b1;
            pw_ended_reg     <= 1'b0;
            auth_failed_reg  <= 1'b0;
        end
        else if (fire)
        begin
            if (s1_last_reg)
            begin
                byte_count_reg   <= '0;
                command_reg      <= '0;
                version_reg      <= '0;
                entry_offset_reg <= '0;
                pw_equal_reg     <= 1'b1;
                pw_ended_reg     <= 1'b0;
                auth_failed_reg  <= 1'b0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                command_reg      <= command_next;
                version_reg      <= version_next;
                entry_offset_reg <= entry_offset_next;
                pw_equal_reg     <= pw_equal_next;
                pw_ended_reg     <= pw_ended_next;
                auth_failed_reg  <= auth_failed_next;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/rpp_out_buf.sv]
// two-entry result buffer in front of the result channel
// depends on rpp_pkg and rpp_result_if
`default_nettype none

module rpp_out_buf
    import rpp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output room_t      room,
    rpp_result_if.source result
);

    logic [1:0] count_reg, count_next;
    logic [1:0] count_left;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop;

    assign pop      = result.valid && result.ready;
    assign room.one = count_reg != 2'd2;
    assign room.two = count_reg == 2'd0;

    always_comb
    begin
        count_left = count_reg - {1'b0, pop};
        head_next  = pop ? tail_reg : head_reg;
        tail_next  = tail_reg;
        if (push.push_a)
        begin
            if (count_left == 2'd0)
                head_next = push.res_a;
            else
                tail_next = push.res_a;
        end
        if (push.push_b)
            tail_next = push.res_b;
        count_next = count_left + {1'b0, push.push_a} + {1'b0, push.push_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign result.valid          = count_reg != 2'd0;
    assign result.kind           = head_reg.kind;
    assign result.command        = head_reg.command;
    assign result.version        = head_reg.version;
    assign result.address_family = head_reg.address_family;
    assign result.route_tag      = head_reg.route_tag;
    assign result.ip_address     = head_reg.ip_address;
    assign result.subnet_mask    = head_reg.subnet_mask;
    assign result.next_hop       = head_reg.next_hop;
    assign result.metric         = head_reg.metric;
    assign result.mask_valid     = head_reg.mask_valid;
    assign result.status         = head_reg.status;
    assign result.end_of_run     = head_reg.end_of_run;

endmodule

`default_nettype wire

[hdl/rip_packet_parser.sv]
// rip packet parser: byte in, route entry and packet status words out
// a byte is held in the input word register, its result words in the result buffer
// throughput: one byte per cycle while the buffer has room; a byte that closes an entry
//   and the packet gives two words, and the next byte needing a slot right after it
//   waits, since free slots come from the registered fill count of the two-entry buffer
// reset: rst_n clears configuration, packet state and all valid flags at once
`default_nettype none

module rip_packet_parser
    import rpp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    rpp_byte_if.sink                    packet,
    rpp_result_if.source                result
);

    // results from the parse stage into the buffer
    push_t push;
    // free slots the buffer reports back, taken from its registered fill count
    room_t room;

    // input word register plus the per-byte parse logic; header latch,
    // streaming password compare on the first entry, entry shift register,
    // auth check and end-of-packet status all sit here
    rpp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .packet    (packet),
        .room      (room),
        .push      (push)
    );

    // result register: two entries so a route word and a status word from
    // the same byte can both land, and the input keeps flowing while the
    // sink stalls for one word
    rpp_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

`default_nettype wire

[hdl/rpp_checker.sv]
// port-level assertions for the rip packet parser, bound to the top level
// depends on rip_packet_parser_assert.svh and rpp_pkg
`default_nettype none

`include "rip_packet_parser_assert.svh"

module rpp_checker
    import rpp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_kind,
    input wire logic [1:0]  out_status,
    input wire logic        out_end,
    input wire logic [31:0] out_metric
);

    // a stalled word holds
    `RPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(out_metric) && $stable(out_status),
        "result word changed while stalled")

    // input only backs up while a result is waiting
    `RPP_ASSERT_NOW(a_stall_cause, !in_ready, out_valid,
        "input stalled with no result pending")

    // a route word that does not end its run is followed by the status word
    `RPP_ASSERT_NEXT(a_route_then_status,
        out_valid && out_ready && (out_kind == KIND_ROUTE) && !out_end,
        out_valid && (out_kind == KIND_STATUS),
        "status word missing after route word")

    // a status word always closes the run
    `RPP_ASSERT_NOW(a_status_ends, out_valid && (out_kind == KIND_STATUS), out_end,
        "status word without end of run")

endmodule

bind rip_packet_parser rpp_checker u_rpp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (packet.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_kind   (result.kind),
    .out_status (result.status),
    .out_end    (result.end_of_run),
    .out_metric (result.metric)
);

`default_nettype wire
